// ===== hdl/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
// No dependencies; every other file but bts_ram refers to it by scoped names.
`timescale 1ns / 1ps

package bts_pkg;

  // Command codes on func_i
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_idx_e;

  // Width of a clamped Q.16 coordinate (0..1.0 inclusive)
  localparam int Q16_W = 17;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  localparam int CFG_W   = 9;
  localparam int TEXEL_W = 24;
  localparam int CHAN_W  = 8;
  localparam int OUT_W   = 16;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Pipeline tag of one beat
  typedef struct packed {
    logic  valid;
    func_e func;
  } ctl_t;

  // Texel write fields
  typedef struct packed {
    logic [7:0]         x;
    logic [7:0]         y;
    logic [TEXEL_W-1:0] rgb;
  } wr_t;

endpackage

// ===== hdl/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bts_coord.sv =====
// Coordinate stages: clamp u and v, flip v, then scale both to texel positions in Q.16.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_coord #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int XW  = $clog2(MAX_WIDTH),
  localparam int YW  = $clog2(MAX_HEIGHT),
  localparam int PUW = bts_pkg::Q16_W + XW,
  localparam int PVW = bts_pkg::Q16_W + YW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bts_pkg::ctl_t      ctl_i,
  input  bts_pkg::wr_t       wr_i,
  input  logic signed [17:0] coord_u_i,
  input  logic signed [17:0] coord_v_i,
  input  logic [XW-1:0]      wm1_i,
  input  logic [YW-1:0]      hm1_i,
  output bts_pkg::ctl_t      ctl_o,
  output bts_pkg::wr_t       wr_o,
  output logic [PUW-1:0]     pu_o,
  output logic [PVW-1:0]     pv_o
);

  // Negative reads as 0, anything above 1.0 as 1.0
  function automatic logic [bts_pkg::Q16_W-1:0] clamp_q16(logic [17:0] c);
    logic [bts_pkg::Q16_W-1:0] r;
    if (c[17]) begin
      r = '0;
    end else if (c[16] && (c[15:0] != '0)) begin
      r = bts_pkg::ONE_Q16;
    end else begin
      r = c[16:0];
    end
    return r;
  endfunction

  bts_pkg::ctl_t             s1_ctl_q, s2_ctl_q;
  bts_pkg::wr_t              s1_wr_q, s2_wr_q;
  logic [bts_pkg::Q16_W-1:0] s1_u_q, s1_vinv_q;
  logic [bts_pkg::Q16_W-1:0] u_d, vinv_d;
  logic [PUW-1:0]            s2_pu_q, pu_d;
  logic [PVW-1:0]            s2_pv_q, pv_d;

  always_comb begin
    u_d    = clamp_q16(coord_u_i);
    vinv_d = bts_pkg::ONE_Q16 - clamp_q16(coord_v_i);
    pu_d   = PUW'(s1_u_q) * PUW'(wm1_i);
    pv_d   = PVW'(s1_vinv_q) * PVW'(hm1_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_wr_q   <= wr_i;
    s1_u_q    <= u_d;
    s1_vinv_q <= vinv_d;
    s2_wr_q   <= s1_wr_q;
    s2_pu_q   <= pu_d;
    s2_pv_q   <= pv_d;
  end

  assign ctl_o = s2_ctl_q;
  assign wr_o  = s2_wr_q;
  assign pu_o  = s2_pu_q;
  assign pv_o  = s2_pv_q;

endmodule

// ===== hdl/bts_fetch.sv =====
// Fetch stage: neighbor indexes, four parity banks of texel RAM, texel writes.
// Depends on bts_pkg and bts_ram.
`timescale 1ns / 1ps

module bts_fetch #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int XW  = $clog2(MAX_WIDTH),
  localparam int YW  = $clog2(MAX_HEIGHT),
  localparam int PUW = bts_pkg::Q16_W + XW,
  localparam int PVW = bts_pkg::Q16_W + YW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bts_pkg::ctl_t               ctl_i,
  input  bts_pkg::wr_t                wr_i,
  input  logic [PUW-1:0]              pu_i,
  input  logic [PVW-1:0]              pv_i,
  input  logic [XW-1:0]               wm1_i,
  input  logic [YW-1:0]               hm1_i,
  output logic                        valid_o,
  output logic [7:0]                  fu_o,
  output logic [7:0]                  fv_o,
  output logic [bts_pkg::TEXEL_W-1:0] tex00_o,
  output logic [bts_pkg::TEXEL_W-1:0] tex10_o,
  output logic [bts_pkg::TEXEL_W-1:0] tex01_o,
  output logic [bts_pkg::TEXEL_W-1:0] tex11_o
);

  // Each bank holds one parity of column and row
  localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic          sample, wr_ok;

  logic [bts_pkg::TEXEL_W-1:0] rdata [4];

  logic       s3_valid_q;
  logic [7:0] s3_fu_q, s3_fv_q;
  logic       s3_x0p_q, s3_x1p_q, s3_y0p_q, s3_y1p_q;

  always_comb begin
    // The position never exceeds size minus one, so the index fits its width
    x0 = pu_i[16 +: XW];
    y0 = pv_i[16 +: YW];
    // Neighbor clamps to the last column or row in use
    x1 = (x0 < wm1_i) ? x0 + XW'(1) : x0;
    y1 = (y0 < hm1_i) ? y0 + YW'(1) : y0;
    sample = ctl_i.valid && (ctl_i.func == bts_pkg::FUNC_SAMPLE);
    // Drop writes outside the store
    wr_ok = ctl_i.valid && (ctl_i.func == bts_pkg::FUNC_WRITE) &&
            (32'(wr_i.x) < MAX_WIDTH) && (32'(wr_i.y) < MAX_HEIGHT);
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit PX = (b % 2) == 1;
    localparam bit PY = (b / 2) == 1;

    logic [XW-1:0] col;
    logic [YW-1:0] row;
    logic [AW-1:0] raddr, waddr;
    logic          we;

    always_comb begin
      // x0 and x1 differ in parity unless they coincide; then both read here
      col   = (x0[0] == PX) ? x0 : x1;
      row   = (y0[0] == PY) ? y0 : y1;
      raddr = AW'(32'(row >> 1) * BANK_COLS + 32'(col >> 1));
      waddr = AW'(32'(wr_i.y >> 1) * BANK_COLS + 32'(wr_i.x >> 1));
      we    = wr_ok && (wr_i.x[0] == PX) && (wr_i.y[0] == PY);
    end

    bts_ram #(
      .WIDTH (bts_pkg::TEXEL_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wr_i.rgb),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= sample;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_fu_q  <= pu_i[15:8];
    s3_fv_q  <= pv_i[15:8];
    s3_x0p_q <= x0[0];
    s3_x1p_q <= x1[0];
    s3_y0p_q <= y0[0];
    s3_y1p_q <= y1[0];
  end

  assign valid_o = s3_valid_q;
  assign fu_o    = s3_fu_q;
  assign fv_o    = s3_fv_q;
  assign tex00_o = rdata[{s3_y0p_q, s3_x0p_q}];
  assign tex10_o = rdata[{s3_y0p_q, s3_x1p_q}];
  assign tex01_o = rdata[{s3_y1p_q, s3_x0p_q}];
  assign tex11_o = rdata[{s3_y1p_q, s3_x1p_q}];

endmodule

// ===== hdl/bts_blend.sv =====
// Blend stages: horizontal blend of each row pair, then vertical blend to Q8.8.
// Depends on bts_pkg.
`timescale 1ns / 1ps

module bts_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [7:0]                  fu_i,
  input  logic [7:0]                  fv_i,
  input  logic [bts_pkg::TEXEL_W-1:0] tex00_i,
  input  logic [bts_pkg::TEXEL_W-1:0] tex10_i,
  input  logic [bts_pkg::TEXEL_W-1:0] tex01_i,
  input  logic [bts_pkg::TEXEL_W-1:0] tex11_i,
  output logic                        valid_o,
  output logic [bts_pkg::OUT_W-1:0]   red_o,
  output logic [bts_pkg::OUT_W-1:0]   green_o,
  output logic [bts_pkg::OUT_W-1:0]   blue_o
);

  logic [8:0] wu0, wu1, wv0, wv1;

  logic [bts_pkg::OUT_W-1:0] top_d [3];
  logic [bts_pkg::OUT_W-1:0] bot_d [3];
  logic [bts_pkg::OUT_W-1:0] top_q [3];
  logic [bts_pkg::OUT_W-1:0] bot_q [3];
  logic [bts_pkg::OUT_W-1:0] res_d [3];
  logic [bts_pkg::OUT_W-1:0] res_q [3];
  logic [7:0]                s4_fv_q;
  logic                      s4_valid_q, s5_valid_q;

  always_comb begin
    wu1 = {1'b0, fu_i};
    wu0 = 9'd256 - wu1;
    wv1 = {1'b0, s4_fv_q};
    wv0 = 9'd256 - wv1;
    // Channel 0 is red in the top byte
    for (int k = 0; k < 3; k++) begin
      top_d[k] = 16'(17'(tex00_i[16-8*k +: 8]) * 17'(wu0) +
                     17'(tex10_i[16-8*k +: 8]) * 17'(wu1));
      bot_d[k] = 16'(17'(tex01_i[16-8*k +: 8]) * 17'(wu0) +
                     17'(tex11_i[16-8*k +: 8]) * 17'(wu1));
      res_d[k] = 16'((25'(top_q[k]) * 25'(wv0) + 25'(bot_q[k]) * 25'(wv1)) >> 8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= valid_i;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_fv_q <= fv_i;
    top_q   <= top_d;
    bot_q   <= bot_d;
    res_q   <= res_d;
  end

  assign valid_o = s5_valid_q;
  assign red_o   = res_q[0];
  assign green_o = res_q[1];
  assign blue_o  = res_q[2];

endmodule

// ===== hdl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: configuration registers and pipeline.
// Depends on bts_pkg, bts_coord, bts_fetch and bts_blend.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------
// command   | in        | start, busy               | func_i, texel_x_i, texel_y_i,
//           |           |                           | texel_rgb_i, coord_u_i, coord_v_i
// result    | out       | result_valid_o (strobe)   | red_o, green_o, blue_o
// config    | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One command beat is taken every cycle; busy stays low. A sample passes the clamp,
// scale, fetch, blend and result registers in turn; a texel write returns nothing.
// The four neighbor texels come from four RAM banks split by row and column
// parity, one read port each, so every sample does its four reads in parallel.
// Reset clears the valid bits and sets both sizes to 256; texel memory is
// not cleared and holds whatever it holds until written.
// The receiver cannot hold results off, so the pipeline never stalls.

module bilinear_texture_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command beat
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic [7:0]                  texel_x_i,
  input  logic [7:0]                  texel_y_i,
  input  logic [bts_pkg::TEXEL_W-1:0] texel_rgb_i,
  input  logic signed [17:0]          coord_u_i,
  input  logic signed [17:0]          coord_v_i,
  // Result beat
  output logic                        result_valid_o,
  output logic [bts_pkg::OUT_W-1:0]   red_o,
  output logic [bts_pkg::OUT_W-1:0]   green_o,
  output logic [bts_pkg::OUT_W-1:0]   blue_o,
  // Configuration writes
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bts_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int PUW = bts_pkg::Q16_W + XW;
  localparam int PVW = bts_pkg::Q16_W + YW;

  logic [bts_pkg::CFG_W-1:0] tex_width_q, tex_height_q;
  logic [XW-1:0]             wm1;
  logic [YW-1:0]             hm1;

  bts_pkg::ctl_t in_ctl, s2_ctl;
  bts_pkg::wr_t  in_wr, s2_wr;
  logic [PUW-1:0] s2_pu;
  logic [PVW-1:0] s2_pv;

  logic                        s3_valid;
  logic [7:0]                  s3_fu, s3_fv;
  logic [bts_pkg::TEXEL_W-1:0] tex00, tex10, tex01, tex11;

  // Every cycle takes a beat
  assign busy = 1'b0;

  // Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= bts_pkg::SIZE_RESET;
      tex_height_q <= bts_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bts_pkg::CFG_TEX_WIDTH: begin
          tex_width_q <= cfg_wdata_i;
        end
        bts_pkg::CFG_TEX_HEIGHT: begin
          tex_height_q <= cfg_wdata_i;
        end
        default: begin
          tex_width_q <= tex_width_q;
        end
      endcase
    end
  end

  // Size minus one: a size of zero acts as one, one above the store as its maximum
  always_comb begin
    if (tex_width_q == '0) begin
      wm1 = '0;
    end else if (32'(tex_width_q) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(tex_width_q - 9'd1);
    end
    if (tex_height_q == '0) begin
      hm1 = '0;
    end else if (32'(tex_height_q) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(tex_height_q - 9'd1);
    end
  end

  // Tag the incoming beat
  always_comb begin
    in_ctl.valid = start && !busy;
    in_ctl.func  = bts_pkg::func_e'(func_i);
    in_wr.x      = texel_x_i;
    in_wr.y      = texel_y_i;
    in_wr.rgb    = texel_rgb_i;
  end

  // Stages 1 and 2: clamp and scale
  bts_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (in_ctl),
    .wr_i      (in_wr),
    .coord_u_i (coord_u_i),
    .coord_v_i (coord_v_i),
    .wm1_i     (wm1),
    .hm1_i     (hm1),
    .ctl_o     (s2_ctl),
    .wr_o      (s2_wr),
    .pu_o      (s2_pu),
    .pv_o      (s2_pv)
  );

  // Stage 3: texel reads and writes in beat order
  bts_fetch #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_fetch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s2_ctl),
    .wr_i    (s2_wr),
    .pu_i    (s2_pu),
    .pv_i    (s2_pv),
    .wm1_i   (wm1),
    .hm1_i   (hm1),
    .valid_o (s3_valid),
    .fu_o    (s3_fu),
    .fv_o    (s3_fv),
    .tex00_o (tex00),
    .tex10_o (tex10),
    .tex01_o (tex01),
    .tex11_o (tex11)
  );

  // Stages 4 and 5: blend and register the result
  bts_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .fu_i    (s3_fu),
    .fv_i    (s3_fv),
    .tex00_i (tex00),
    .tex10_i (tex10),
    .tex01_i (tex01),
    .tex11_i (tex11),
    .valid_o (result_valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule
